### rtl/core/as2f_pkg.sv
`default_nettype none
package as2f_pkg;
   localparam logic [4:0] FMT_I16 = 5'd16;
   localparam logic [4:0] FMT_I24 = 5'd17;
   localparam logic [4:0] FMT_I32 = 5'd18;
   localparam logic [4:0] FMT_F32 = 5'd19;
   localparam logic [4:0] FMT_F64 = 5'd20;
   localparam logic [4:0] FMT_I32_A = 5'd24;
   localparam logic [4:0] FMT_I32_B = 5'd25;
   localparam logic [4:0] FMT_I32_C = 5'd26;
   localparam logic [4:0] FMT_I32_D = 5'd27;
   localparam logic [4:0] FMT_RESET = 5'd18;

   localparam logic [1:0] KIND_ZERO = 2'd0;
   localparam logic [1:0] KIND_NUM = 2'd1;
   localparam logic [1:0] KIND_DIRECT = 2'd2;

   // decoded, not yet normalized operand handed from the decode stage to the shift stage
   typedef struct packed {
      logic [1:0] kind;
      logic sign;
      logic [52:0] mag;
      logic signed [12:0] e;
      logic [31:0] direct;
      logic ok;
   } dec_type;

   // rounding operand: kept bits plus guard and sticky
   typedef struct packed {
      logic [1:0] kind;
      logic sign;
      logic normal;
      logic [24:0] m;
      logic guard;
      logic sticky;
      logic signed [12:0] big_e;
      logic [31:0] direct;
      logic ok;
   } rnd_type;
endpackage
`default_nettype wire

### rtl/core/as2f_decode.sv
`default_nettype none
module as2f_decode (
   input wire logic [4:0] sample_format,
   input wire logic [63:0] raw_sample,
   output as2f_pkg::dec_type dec
);
   logic [31:0] v32;
   logic [31:0] mag32;
   logic neg;
   logic signed [12:0] ie;
   logic [10:0] dex;
   logic [51:0] dfrac;

   always_comb begin
      dec = '0;
      v32 = '0;
      neg = 1'b0;
      ie = '0;
      mag32 = '0;
      dex = raw_sample[62:52];
      dfrac = raw_sample[51:0];
      dec.ok = 1'b1;
      unique case (sample_format)
         as2f_pkg::FMT_I16: begin
            v32 = {{16{raw_sample[15]}}, raw_sample[15:0]};
            ie = -13'sd15;
         end
         as2f_pkg::FMT_I24: begin
            v32 = {{8{raw_sample[23]}}, raw_sample[23:0]};
            ie = -13'sd23;
         end
         as2f_pkg::FMT_I32, as2f_pkg::FMT_I32_A, as2f_pkg::FMT_I32_B,
         as2f_pkg::FMT_I32_C, as2f_pkg::FMT_I32_D: begin
            v32 = raw_sample[31:0];
            ie = -13'sd31;
         end
         default: ;
      endcase
      neg = v32[31];
      mag32 = neg ? (~v32 + 32'd1) : v32;
      unique case (sample_format)
         as2f_pkg::FMT_I16, as2f_pkg::FMT_I24, as2f_pkg::FMT_I32,
         as2f_pkg::FMT_I32_A, as2f_pkg::FMT_I32_B, as2f_pkg::FMT_I32_C,
         as2f_pkg::FMT_I32_D: begin
            dec.sign = neg;
            dec.mag = {21'd0, mag32};
            dec.e = ie;
            dec.kind = (mag32 == 32'd0) ? as2f_pkg::KIND_ZERO : as2f_pkg::KIND_NUM;
         end
         as2f_pkg::FMT_F32: begin
            dec.kind = as2f_pkg::KIND_DIRECT;
            dec.direct = raw_sample[31:0];
            if (raw_sample[30:23] == 8'hff && raw_sample[22:0] != 23'd0) begin
               dec.direct[22] = 1'b1;
            end
         end
         as2f_pkg::FMT_F64: begin
            dec.sign = raw_sample[63];
            if (dex == 11'h7ff) begin
               dec.kind = as2f_pkg::KIND_DIRECT;
               dec.direct = {raw_sample[63], 8'hff, (dfrac != 52'd0), dfrac[50:29]};
            end else if (dex == 11'd0) begin
               dec.mag = {1'b0, dfrac};
               dec.e = -13'sd1074;
               dec.kind = (dfrac == 52'd0) ? as2f_pkg::KIND_ZERO : as2f_pkg::KIND_NUM;
            end else begin
               dec.mag = {1'b1, dfrac};
               dec.e = $signed({2'b00, dex}) - 13'sd1075;
               dec.kind = as2f_pkg::KIND_NUM;
            end
         end
         default: begin
            dec.ok = 1'b0;
            dec.kind = as2f_pkg::KIND_DIRECT;
         end
      endcase
   end
endmodule
`default_nettype wire

### rtl/core/as2f_align.sv
`default_nettype none
module as2f_align (
   input wire as2f_pkg::dec_type dec,
   output as2f_pkg::rnd_type rnd
);
   logic [5:0] p;
   logic signed [12:0] big_e;
   logic signed [12:0] shift;
   logic [53:0] ext;
   logic [107:0] wide;
   logic [6:0] rs;
   logic [6:0] ls;

   always_comb begin
      p = '0;
      for (int i = 0; i < 53; i++) begin
         if (dec.mag[i]) begin
            p = 6'(i);
         end
      end
      big_e = $signed({7'd0, p}) + dec.e;
      rnd = '0;
      rnd.kind = dec.kind;
      rnd.sign = dec.sign;
      rnd.direct = dec.direct;
      rnd.ok = dec.ok;
      rnd.big_e = big_e;
      rnd.normal = big_e >= -13'sd126;
      shift = rnd.normal ? ($signed({7'd0, p}) - 13'sd23) : (-13'sd149 - dec.e);
      ext = {1'b0, dec.mag};
      wide = '0;
      rs = '0;
      ls = '0;
      if (shift <= 0) begin
         ls = 7'(-shift);
         wide = {54'd0, ext} << ls;
         rnd.m = wide[24:0];
      end else if (shift > 13'sd60) begin
         rnd.m = '0;
         rnd.guard = 1'b0;
         rnd.sticky = dec.mag != 53'd0;
      end else begin
         rs = 7'(shift);
         wide = {ext, 54'd0} >> rs;
         rnd.m = wide[78:54];
         rnd.guard = wide[53];
         rnd.sticky = wide[52:0] != 53'd0;
      end
   end
endmodule
`default_nettype wire

### rtl/core/as2f_round.sv
`default_nettype none
module as2f_round (
   input wire as2f_pkg::rnd_type rnd,
   output logic [31:0] float_bits,
   output logic format_ok
);
   logic [24:0] m;
   logic signed [12:0] biased;

   always_comb begin
      m = rnd.m + 25'((rnd.guard && (rnd.sticky || rnd.m[0])) ? 1 : 0);
      biased = rnd.big_e + 13'sd127;
      if (m[24]) begin
         m = m >> 1;
         biased = biased + 13'sd1;
      end
      format_ok = rnd.ok;
      unique case (rnd.kind)
         as2f_pkg::KIND_DIRECT: float_bits = rnd.direct;
         as2f_pkg::KIND_NUM: begin
            if (!rnd.normal) begin
               float_bits = {rnd.sign, 7'd0, m[23:0]};
            end else if (biased >= 13'sd255) begin
               float_bits = {rnd.sign, 8'hff, 23'd0};
            end else begin
               float_bits = {rnd.sign, biased[7:0], m[22:0]};
            end
         end
         default: float_bits = {rnd.sign, 31'd0};
      endcase
   end
endmodule
`default_nettype wire

### rtl/core/audio_sample_to_float32_core.sv
// Converts one raw sample word per cycle, when rsp_ready does not stall it, to an
// IEEE single, in the layout set by csr_sample_format (reset 18). Three register
// stages (decode, align, round) sit behind the req side; the edge that takes a beat
// loads the first stage, and its result then passes the align and round registers
// before it is presented on rsp; the pipeline advances whenever its output register
// is empty or being taken, giving one beat per cycle sustained while rsp_ready is high.
`default_nettype none
module audio_sample_to_float32_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_write_enable,
   input wire logic [4:0] csr_sample_format,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [63:0] req_raw_sample,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [31:0] rsp_float_bits,
   output logic rsp_format_ok
);
   logic [4:0] fmt_ff;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   as2f_pkg::dec_type s1_ff, s1_in;
   as2f_pkg::rnd_type s2_ff, s2_in;
   logic [31:0] s3_bits_ff, s3_bits_in;
   logic s3_ok_ff, s3_ok_in;
   logic adv3, adv2, adv1;

   assign adv3 = !s3_valid_ff || rsp_ready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_ready = adv1;

   as2f_decode u_dec (.sample_format(fmt_ff), .raw_sample(req_raw_sample), .dec(s1_in));
   as2f_align u_aln (.dec(s1_ff), .rnd(s2_in));
   as2f_round u_rnd (.rnd(s2_ff), .float_bits(s3_bits_in), .format_ok(s3_ok_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= as2f_pkg::FMT_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            fmt_ff <= csr_sample_format;
         end
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff <= s1_in;
      end
      if (adv2) begin
         s2_ff <= s2_in;
      end
      if (adv3) begin
         s3_bits_ff <= s3_bits_in;
         s3_ok_ff <= s3_ok_in;
      end
   end

   assign rsp_valid = s3_valid_ff;
   assign rsp_float_bits = s3_bits_ff;
   assign rsp_format_ok = s3_ok_ff;

`ifndef SYNTHESIS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_float_bits))
      else $error("result changed under stall");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_format_ok |-> rsp_float_bits == 32'd0)
      else $error("unsupported format gave nonzero");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("stalled with empty first stage");
`endif
endmodule
`default_nettype wire

### tb/audio_sample_to_float32_checker.sv
`default_nettype none
module audio_sample_to_float32_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_write_enable,
   input wire logic [4:0] csr_sample_format,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic [63:0] req_raw_sample,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [31:0] rsp_float_bits,
   input wire logic rsp_format_ok,
   output int fail_count,
   output int pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EXP_DEPTH = 64;

   typedef struct packed {
      logic [31:0] float_bits;
      logic format_ok;
   } sample_out_t;

   logic [4:0] fmt_shadow;
   sample_out_t exp_mem[EXP_DEPTH];
   int exp_wr;
   int exp_rd;

   function automatic int msb_index(logic [63:0] v);
      int p;
      p = 0;
      for (int i = 0; i < 64; i++)
         if (v[i]) p = i;
      return p;
   endfunction

   function automatic logic [31:0] round_to_single(logic sgn, logic [63:0] mag, int e);
      int p, big_e, shift, biased;
      logic [63:0] m, rem, half;
      logic normal;
      if (mag == 0) return {sgn, 31'd0};
      p = msb_index(mag);
      big_e = p + e;
      normal = (big_e >= -126);
      shift = normal ? (p - 23) : (-149 - e);
      if (shift <= 0) begin
         m = mag << (-shift);
      end else if (shift > 64) begin
         return {sgn, 31'd0};
      end else if (shift == 64) begin
         m = (mag > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
      end else begin
         rem = mag & ((64'd1 << shift) - 64'd1);
         half = 64'd1 << (shift - 1);
         m = mag >> shift;
         if (rem > half || (rem == half && m[0])) m = m + 1;
      end
      if (normal) begin
         biased = big_e + 127;
         if (m == (64'd1 << 24)) begin
            m = m >> 1;
            biased++;
         end
         if (biased >= 255) return {sgn, 8'hff, 23'd0};
         return {sgn, biased[7:0], m[22:0]};
      end
      return {sgn, 31'd0} | m[31:0];
   endfunction

   function automatic logic [31:0] int_to_single(logic [63:0] raw, int width, int e);
      logic [63:0] mask, v, mag;
      logic neg;
      mask = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
      v = raw & mask;
      neg = v[width-1];
      mag = neg ? ((~v + 64'd1) & mask) : v;
      if (neg && mag == 0) mag = 64'd1 << (width - 1);
      return round_to_single(neg, mag, e);
   endfunction

   function automatic logic [31:0] double_to_single(logic [63:0] x);
      logic [10:0] ex;
      logic [51:0] frac;
      ex = x[62:52];
      frac = x[51:0];
      if (ex == 11'h7ff) begin
         if (frac == 0) return {x[63], 8'hff, 23'd0};
         return {x[63], 8'hff, 1'b1, frac[50:29]};
      end
      if (ex == 0) return round_to_single(x[63], {12'd0, frac}, -1074);
      return round_to_single(x[63], {11'd0, 1'b1, frac}, int'(ex) - 1075);
   endfunction

   function automatic sample_out_t convert_sample(logic [4:0] fmt, logic [63:0] raw);
      sample_out_t r;
      r.format_ok = 1'b1;
      r.float_bits = '0;
      case (fmt)
         as2f_pkg::FMT_I16: r.float_bits = int_to_single(raw, 16, -15);
         as2f_pkg::FMT_I24: r.float_bits = int_to_single(raw, 24, -23);
         as2f_pkg::FMT_I32, as2f_pkg::FMT_I32_A, as2f_pkg::FMT_I32_B,
         as2f_pkg::FMT_I32_C, as2f_pkg::FMT_I32_D:
            r.float_bits = int_to_single(raw, 32, -31);
         as2f_pkg::FMT_F32: begin
            r.float_bits = raw[31:0];
            if (raw[30:23] == 8'hff && raw[22:0] != 0) r.float_bits[22] = 1'b1;
         end
         as2f_pkg::FMT_F64: r.float_bits = double_to_single(raw);
         default: r.format_ok = 1'b0;
      endcase
      return r;
   endfunction

   assign pending_count = exp_wr - exp_rd;

   always @(posedge clock) begin
      sample_out_t want;
      if (reset) begin
         fmt_shadow <= as2f_pkg::FMT_RESET;
         exp_wr <= 0;
         exp_rd <= 0;
         fail_count <= 0;
      end else begin
         if (csr_write_enable) fmt_shadow <= csr_sample_format;
         if (req_valid && req_ready) begin
            exp_mem[exp_wr % EXP_DEPTH] <= convert_sample(fmt_shadow, req_raw_sample);
            exp_wr <= exp_wr + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (exp_wr == exp_rd) begin
               $display("%0t: unexpected beat float_bits=%h format_ok=%b", $time,
                  rsp_float_bits, rsp_format_ok);
               fail_count <= fail_count + 1;
            end else begin
               want = exp_mem[exp_rd % EXP_DEPTH];
               exp_rd <= exp_rd + 1;
               if (want.float_bits !== rsp_float_bits ||
                     want.format_ok !== rsp_format_ok) begin
                  $display("%0t: mismatch expected %h/%b actual %h/%b", $time,
                     want.float_bits, want.format_ok, rsp_float_bits, rsp_format_ok);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

### tb/audio_sample_to_float32_core_tb.sv
`default_nettype none
module audio_sample_to_float32_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [4:0] csr_sample_format = as2f_pkg::FMT_RESET;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [63:0] req_raw_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_float_bits;
   logic rsp_format_ok;
   int fail_count;
   int pending_count;
   int idle_cycles = 0;
   logic hold_off = 1'b0;

   audio_sample_to_float32_core u_dut (.*);
   audio_sample_to_float32_checker u_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic logic [63:0] random_word(logic [4:0] fmt);
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: w = '0;
         1: w = '1;
         2: w[62:52] = 11'h7ff;
         3: w[62:52] = $urandom_range(0, 1) ? 11'h0 : 11'(896 + $urandom_range(0, 40));
         4: w[62:52] = 11'(1150 + $urandom_range(0, 10));
         5: w[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
         6: w[31:0] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         7: w[23:0] = $urandom_range(0, 1) ? 24'h80_0000 : 24'h00_0001;
         default: ;
      endcase
      return w;
   endfunction

   // receiver: random backpressure, plus one long hold-off on request
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (60) @(posedge clock);
            hold_off = 1'b0;
         end
         n = gap_len();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_beat(logic [63:0] raw);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_sample <= raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_and_write(logic [4:0] fmt);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_sample_format <= fmt;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      static logic [4:0] fmt_list[] = '{as2f_pkg::FMT_I32, as2f_pkg::FMT_I16,
         as2f_pkg::FMT_I24, as2f_pkg::FMT_F32, as2f_pkg::FMT_F64, as2f_pkg::FMT_I32_A,
         as2f_pkg::FMT_I32_B, as2f_pkg::FMT_I32_C, as2f_pkg::FMT_I32_D,
         5'd0, 5'd31, 5'd21};
      static logic [63:0] directed[] = '{64'h0, 64'h7fff, 64'h8000, 64'hffff_ffff_ffff_ffff,
         64'h7f_ffff, 64'h80_0000, 64'h7fff_ffff, 64'h8000_0000, 64'h7fc0_0001,
         64'hff80_0000, 64'h0000_0001, 64'h7ff0_0000_0000_0000,
         64'hfff0_0000_0000_0001, 64'h7fef_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
         64'h47ef_ffff_f000_0000, 64'h3690_0000_0000_0000, 64'h36a0_0000_0000_0001,
         64'h3800_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h0000_0001_0000_0000};
      logic [4:0] fmt;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_beat(directed[i]);
      foreach (fmt_list[k]) begin
         drain_and_write(fmt_list[k]);
         foreach (directed[i]) send_beat(directed[i]);
      end
      for (int ph = 0; ph < 12; ph++) begin
         fmt = ($urandom_range(0, 7) == 0) ? 5'($urandom) : fmt_list[$urandom_range(0, 8)];
         drain_and_write(fmt);
         if (ph == 3) begin
            hold_off = 1'b1;
            repeat (100) send_beat(random_word(fmt));
         end
         repeat (80) send_beat(random_word(fmt));
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end
endmodule
`default_nettype wire
